// File: design/tkcl_pkg.sv
// Shared types, sizes and codes of the two-key code lock.
`timescale 1ns / 1ps

package tkcl_pkg;

    // Digits in one code and samples needed to accept a key level.
    localparam int CODE_LENGTH    = 6;
    localparam int STABLE_SAMPLES = 6;
    localparam int CNT_W          = $clog2(CODE_LENGTH + 1);

    localparam int PERIOD_W    = 10;
    localparam int TOGGLE_W    = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 10;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd80;
    localparam logic [TOGGLE_W-1:0] TOGGLE_RESET = 5'd8;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PERIOD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_TOGGLES = 1'd1;

    // LED colors.
    localparam logic [1:0] LED_GREEN  = 2'd0;
    localparam logic [1:0] LED_RED    = 2'd1;
    localparam logic [1:0] LED_YELLOW = 2'd2;
    localparam logic [1:0] LED_DARK   = 2'd3;

    // Lock events.
    localparam logic [1:0] EVT_NONE   = 2'd0;
    localparam logic [1:0] EVT_STORED = 2'd1;
    localparam logic [1:0] EVT_OPEN   = 2'd2;
    localparam logic [1:0] EVT_WRONG  = 2'd3;

    typedef enum logic [2:0] {
        MODE_ENTRY  = 3'b001,
        MODE_LOCKED = 3'b010,
        MODE_FLASH  = 3'b100
    } lock_mode_t;

    typedef struct packed {
        logic key_a_level;
        logic key_b_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0] led_color;
        logic       press_echo;
        logic [1:0] lock_event;
        logic [2:0] presses_entered;
    } out_item_t;

endpackage

// File: design/tkcl_debounce.sv
// One key lane: sample history, held/armed tracking and fresh-press detect.
`timescale 1ns / 1ps

module tkcl_debounce (
    input  logic aclk,
    input  logic aresetn,
    input  logic advance,
    input  logic key_level,
    output logic press
);
    import tkcl_pkg::*;

    logic [STABLE_SAMPLES-1:0] hist_reg, hist_next;
    logic                      held_reg, held_next;
    logic                      armed_reg, armed_next;

    always_comb begin
        hist_next  = {hist_reg[STABLE_SAMPLES-2:0], ~key_level};
        held_next  = held_reg;
        armed_next = armed_reg;
        if (&hist_next) begin
            held_next = 1'b1;
        end
        if (hist_next == '0) begin
            held_next  = 1'b0;
            armed_next = 1'b1;
        end
        press = held_next && armed_next;
        if (press) begin
            armed_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= '0;
            held_reg  <= 1'b0;
            armed_reg <= 1'b1;
        end else if (advance) begin
            hist_reg  <= hist_next;
            held_reg  <= held_next;
            armed_reg <= armed_next;
        end
    end

endmodule

// File: design/tkcl_ctrl.sv
// Merge stage: records digits from both lanes, runs the lock modes and flash timer.
`timescale 1ns / 1ps

module tkcl_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic                       press_a,
    input  logic                       press_b,
    input  logic                       cfg_wr_en,
    input  logic [tkcl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tkcl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output tkcl_pkg::out_item_t        result
);
    import tkcl_pkg::*;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_LENGTH);

    logic [PERIOD_W-1:0]    period_cfg_reg;
    logic [TOGGLE_W-1:0]    toggle_cfg_reg;

    logic [CNT_W-1:0]       count_reg, count_next, count_a;
    logic [CODE_LENGTH-1:0] entered_reg, entered_next, entered_a;
    logic [CODE_LENGTH-1:0] stored_reg, stored_next;
    lock_mode_t             mode_reg, mode_next;
    logic [PERIOD_W-1:0]    timer_reg, timer_next, timer_inc, period;
    logic [TOGGLE_W-1:0]    toggles_reg, toggles_next, toggles_inc, toggle_limit;
    logic                   yellow_reg, yellow_next;
    logic                   rec_a, rec_b;
    logic                   flashing;
    logic [1:0]             event_code;
    logic [1:0]             color;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_cfg_reg <= PERIOD_RESET;
            toggle_cfg_reg <= TOGGLE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FLASH_PERIOD:  period_cfg_reg <= cfg_wdata[PERIOD_W-1:0];
                CFG_FLASH_TOGGLES: toggle_cfg_reg <= cfg_wdata[TOGGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero setting acts as one.
    assign period       = (period_cfg_reg == '0) ? PERIOD_W'(1) : period_cfg_reg;
    assign toggle_limit = (toggle_cfg_reg == '0) ? TOGGLE_W'(1) : toggle_cfg_reg;
    assign timer_inc    = timer_reg + PERIOD_W'(1);
    assign toggles_inc  = toggles_reg + TOGGLE_W'(1);
    assign flashing     = (mode_reg == MODE_FLASH);

    always_comb begin
        // Key A first, then key B; drop digits beyond the code length.
        rec_a     = press_a && !flashing && (count_reg < CNT_FULL);
        entered_a = rec_a ? (entered_reg | (CODE_LENGTH'(1) << count_reg)) : entered_reg;
        count_a   = rec_a ? count_reg + CNT_W'(1) : count_reg;

        rec_b        = press_b && !flashing && (count_a < CNT_FULL);
        entered_next = rec_b ? (entered_a & ~(CODE_LENGTH'(1) << count_a)) : entered_a;
        count_next   = rec_b ? count_a + CNT_W'(1) : count_a;

        stored_next  = stored_reg;
        mode_next    = mode_reg;
        timer_next   = timer_reg;
        toggles_next = toggles_reg;
        yellow_next  = yellow_reg;
        event_code   = EVT_NONE;

        if (!flashing && count_next >= CNT_FULL) begin
            if (mode_reg == MODE_LOCKED) begin
                if (entered_next == stored_reg) begin
                    mode_next  = MODE_ENTRY;
                    count_next = '0;
                    event_code = EVT_OPEN;
                end else begin
                    mode_next    = MODE_FLASH;
                    timer_next   = '0;
                    toggles_next = '0;
                    yellow_next  = 1'b1;
                    event_code   = EVT_WRONG;
                end
            end else begin
                stored_next = entered_next;
                mode_next   = MODE_LOCKED;
                count_next  = '0;
                event_code  = EVT_STORED;
            end
            entered_next = '0;
        end else if (flashing) begin
            timer_next = timer_inc;
            if (timer_inc >= period) begin
                timer_next   = '0;
                yellow_next  = ~yellow_reg;
                toggles_next = toggles_inc;
                if (toggles_inc >= toggle_limit) begin
                    toggles_next = '0;
                    yellow_next  = 1'b0;
                    mode_next    = MODE_LOCKED;
                    count_next   = '0;
                    entered_next = '0;
                end
            end
        end

        unique case (mode_next)
            MODE_LOCKED: color = LED_RED;
            MODE_FLASH:  color = yellow_next ? LED_YELLOW : LED_DARK;
            default:     color = LED_GREEN;
        endcase

        result.led_color       = color;
        result.press_echo      = rec_a || rec_b;
        result.lock_event      = event_code;
        result.presses_entered = 3'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            entered_reg <= '0;
            stored_reg  <= '0;
            mode_reg    <= MODE_ENTRY;
            timer_reg   <= '0;
            toggles_reg <= '0;
            yellow_reg  <= 1'b0;
        end else if (advance) begin
            count_reg   <= count_next;
            entered_reg <= entered_next;
            stored_reg  <= stored_next;
            mode_reg    <= mode_next;
            timer_reg   <= timer_next;
            toggles_reg <= toggles_next;
            yellow_reg  <= yellow_next;
        end
    end

endmodule

// File: design/two_key_code_lock.sv
// Top level of the two-key code lock: key lanes, merge stage and output buffer.
`timescale 1ns / 1ps

// Each input transfer is one sample tick of the two raw active-low key levels
// and yields exactly one registered result. The block takes one tick per
// cycle: both key lanes and the lock controller update on every accepted
// tick, and a two-entry output buffer keeps input flowing while a result
// waits, so s_ready drops only when both entries are full. The flash timing
// registers are written through the cfg port (index 0 period, 1 toggle count).

module two_key_code_lock (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tkcl_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tkcl_pkg::out_item_t             m_data,
    input  logic                            cfg_wr_en,
    input  logic [tkcl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tkcl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tkcl_pkg::*;

    logic      accept;
    logic      press_a, press_b;
    out_item_t result;
    logic      out_valid_reg, skid_valid_reg;
    out_item_t out_data_reg, skid_data_reg;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    tkcl_debounce u_lane_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (accept),
        .key_level (s_data.key_a_level),
        .press     (press_a)
    );

    tkcl_debounce u_lane_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (accept),
        .key_level (s_data.key_b_level),
        .press     (press_b)
    );

    tkcl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (accept),
        .press_a   (press_a),
        .press_b   (press_b),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            // Output slot frees up: refill from the skid entry first.
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end else if (accept) begin
            skid_data_reg <= result;
        end
    end

endmodule

// File: tb/sv/two_key_code_lock_tb.sv
// Self-checking testbench of the two-key code lock: directed drills, then random key traffic.
`timescale 1ns / 1ps

module two_key_code_lock_tb;
    import tkcl_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int NUM_DRILLS  = 20;
    localparam int NUM_PHASES  = 8;

    typedef struct packed {
        logic [STABLE_SAMPLES-1:0] hist;
        logic                      held;
        logic                      armed;
    } key_t;

    // One drill row: key levels held for some ticks, then both keys up for some ticks.
    typedef struct packed {
        logic      a_level;
        logic      b_level;
        logic [9:0] hold;
        logic [3:0] rel;
        logic      fixed_en;
        out_item_t fixed;
    } drill_row_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] period;
        logic [CFG_DATA_W-1:0] toggles_word;
        logic [11:0]           ticks;
        logic [6:0]            gap_pct;
    } phase_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '1;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FLASH_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Lock state as the checker sees it.
    logic [PERIOD_W-1:0]    flash_period_q;
    logic [TOGGLE_W-1:0]    flash_count_q;
    key_t                   key_a_q, key_b_q;
    logic [CNT_W-1:0]       digit_cnt_q;
    logic [CODE_LENGTH-1:0] entered_q, stored_q;
    lock_mode_t             mode_q;
    logic [PERIOD_W-1:0]    flash_timer_q;
    logic [TOGGLE_W-1:0]    toggles_q;
    logic                   yellow_q;

    out_item_t expected_q[$];
    out_item_t tick_result, want;
    logic      tick_fixed_en = 1'b0;
    out_item_t tick_fixed = '0;
    int        errors = 0;
    int        ticks_sent = 0;
    int        gap_pct = 0;
    bit        replay = 1'b0;

    // Lock state sampled away from the active edge, to steer the key stimulus.
    logic                   hint_locked = 1'b0;
    logic [CNT_W-1:0]       hint_count = '0;
    logic [CODE_LENGTH-1:0] hint_code = '0;

    drill_row_t drill_rows [NUM_DRILLS];
    phase_t     phases [NUM_PHASES];

    two_key_code_lock u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic void reset_lock_model();
        flash_period_q = PERIOD_RESET;
        flash_count_q  = TOGGLE_RESET;
        key_a_q        = '{hist: '0, held: 1'b0, armed: 1'b1};
        key_b_q        = '{hist: '0, held: 1'b0, armed: 1'b1};
        digit_cnt_q    = '0;
        entered_q      = '0;
        stored_q       = '0;
        mode_q         = MODE_ENTRY;
        flash_timer_q  = '0;
        toggles_q      = '0;
        yellow_q       = 1'b0;
    endfunction

    // Shift in one sample; a fresh press fires once per hold.
    function automatic logic key_step(input logic level, inout key_t k);
        k.hist = {k.hist[STABLE_SAMPLES-2:0], ~level};
        if (&k.hist)
            k.held = 1'b1;
        if (k.hist == '0) begin
            k.held  = 1'b0;
            k.armed = 1'b1;
        end
        if (k.held && k.armed) begin
            k.armed = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic enter_digit(input logic digit);
        if (mode_q == MODE_FLASH || digit_cnt_q >= CODE_LENGTH)
            return 1'b0;
        entered_q[digit_cnt_q] = digit;
        digit_cnt_q = digit_cnt_q + 1'b1;
        return 1'b1;
    endfunction

    function automatic out_item_t predict_tick(input in_item_t item);
        out_item_t           r;
        logic                was_flashing, press_a, press_b, echo;
        logic [1:0]          evt;
        logic [PERIOD_W-1:0] period_eff;
        logic [TOGGLE_W-1:0] count_eff;
        was_flashing = (mode_q == MODE_FLASH);
        echo = 1'b0;
        evt  = EVT_NONE;
        press_a = key_step(item.key_a_level, key_a_q);
        press_b = key_step(item.key_b_level, key_b_q);
        // Key A goes first, so B can be dropped once A completes the code.
        if (press_a)
            echo = enter_digit(1'b1) | echo;
        if (press_b)
            echo = enter_digit(1'b0) | echo;

        if (mode_q != MODE_FLASH && digit_cnt_q >= CODE_LENGTH) begin
            if (mode_q == MODE_LOCKED) begin
                if (entered_q == stored_q) begin
                    mode_q      = MODE_ENTRY;
                    digit_cnt_q = '0;
                    evt         = EVT_OPEN;
                end else begin
                    mode_q        = MODE_FLASH;
                    flash_timer_q = '0;
                    toggles_q     = '0;
                    yellow_q      = 1'b1;
                    evt           = EVT_WRONG;
                end
            end else begin
                stored_q    = entered_q;
                mode_q      = MODE_LOCKED;
                digit_cnt_q = '0;
                evt         = EVT_STORED;
            end
            entered_q = '0;
        end else if (was_flashing) begin
            period_eff = (flash_period_q == '0) ? PERIOD_W'(1) : flash_period_q;
            count_eff  = (flash_count_q == '0) ? TOGGLE_W'(1) : flash_count_q;
            flash_timer_q = flash_timer_q + 1'b1;
            if (flash_timer_q >= period_eff) begin
                flash_timer_q = '0;
                yellow_q      = ~yellow_q;
                toggles_q     = toggles_q + 1'b1;
                if (toggles_q >= count_eff) begin
                    toggles_q   = '0;
                    yellow_q    = 1'b0;
                    mode_q      = MODE_LOCKED;
                    digit_cnt_q = '0;
                    entered_q   = '0;
                end
            end
        end

        if (mode_q == MODE_LOCKED)
            r.led_color = LED_RED;
        else if (mode_q == MODE_FLASH)
            r.led_color = yellow_q ? LED_YELLOW : LED_DARK;
        else
            r.led_color = LED_GREEN;
        r.press_echo      = echo;
        r.lock_event      = evt;
        r.presses_entered = digit_cnt_q;
        return r;
    endfunction

    // Check results first, then queue the prediction for this edge's input transfer.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $error("result transfer with no expectation: %p", m_data);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (m_data.led_color !== want.led_color) begin
                    $error("led_color: expected %0d, got %0d", want.led_color, m_data.led_color);
                    errors++;
                end
                if (m_data.press_echo !== want.press_echo) begin
                    $error("press_echo: expected %0d, got %0d",
                           want.press_echo, m_data.press_echo);
                    errors++;
                end
                if (m_data.lock_event !== want.lock_event) begin
                    $error("lock_event: expected %0d, got %0d",
                           want.lock_event, m_data.lock_event);
                    errors++;
                end
                if (m_data.presses_entered !== want.presses_entered) begin
                    $error("presses_entered: expected %0d, got %0d",
                           want.presses_entered, m_data.presses_entered);
                    errors++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            tick_result = predict_tick(s_data);
            if (tick_fixed_en)
                tick_result = tick_fixed;
            expected_q.push_back(tick_result);
        end
    end

    always @(negedge aclk) begin
        hint_locked <= (mode_q == MODE_LOCKED);
        hint_count  <= digit_cnt_q;
        hint_code   <= stored_q;
    end

    initial begin : result_sink
        int run;
        @(posedge aclk);
        forever begin
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            m_ready <= 1'b0;
            repeat (run) @(posedge aclk);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn)
                idle = 0;
            else
                idle++;
        end
        $display("two_key_code_lock_tb failed");
        $finish;
    end

    // Present one sample tick and hold it until the transfer.
    task automatic send_tick(input logic a_lvl, input logic b_lvl,
                             input logic fixed_en, input out_item_t fixed);
        int gap;
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data        <= '{key_a_level: a_lvl, key_b_level: b_lvl};
        tick_fixed_en <= fixed_en;
        tick_fixed    <= fixed;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    // Hold the given levels, then let both keys up; optionally pin the last held tick.
    task automatic press(input logic a_lvl, input logic b_lvl, input int hold, input int rel,
                         input logic fixed_en, input out_item_t fixed);
        for (int i = 0; i < hold; i++)
            send_tick(a_lvl, b_lvl, fixed_en && (i == hold - 1), fixed);
        repeat (rel) send_tick(1'b1, 1'b1, 1'b0, '0);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
    endtask

    task automatic write_flash_cfg(input logic [CFG_DATA_W-1:0] period,
                                   input logic [CFG_DATA_W-1:0] toggles_word);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FLASH_PERIOD;
        cfg_wdata <= period;
        @(posedge aclk);
        cfg_index <= CFG_FLASH_TOGGLES;
        cfg_wdata <= toggles_word;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        flash_period_q = period[PERIOD_W-1:0];
        flash_count_q  = toggles_word[TOGGLE_W-1:0];
    endtask

    // One clean digit press; in locked mode usually replay the stored code.
    task automatic random_digit();
        logic on_a, on_b;
        int   hold, rel;
        if (hint_count == 0)
            replay = ($urandom_range(0, 2) != 0);
        if (hint_locked && replay && hint_count < CODE_LENGTH) begin
            on_a = hint_code[hint_count];
            on_b = ~on_a;
        end else if ($urandom_range(0, 99) < 15) begin
            on_a = 1'b1;
            on_b = 1'b1;
        end else begin
            on_a = 1'($urandom_range(0, 1));
            on_b = ~on_a;
        end
        hold = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(6, 9);
        rel  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 15) : $urandom_range(6, 9);
        press(~on_a, ~on_b, hold, rel, 1'b0, '0);
    endtask

    task automatic random_burst();
        int   pick, n;
        logic a_lvl;
        pick = $urandom_range(0, 99);
        if (pick == 0) begin
            drain_results();
        end else if (pick < 70) begin
            random_digit();
        end else if (pick < 80) begin
            // contact bounce on both keys
            n = $urandom_range(1, 8);
            repeat (n) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
        end else if (pick < 88) begin
            a_lvl = 1'($urandom_range(0, 1));
            press(a_lvl, ~a_lvl, $urandom_range(1, 5), $urandom_range(1, 3), 1'b0, '0);
        end else if (pick < 95) begin
            press(1'b1, 1'b1, $urandom_range(1, 20), 0, 1'b0, '0);
        end else begin
            // overlapping presses: A down first, B joins, A lets go first
            n = $urandom_range(1, 4);
            press(1'b0, 1'b1, n, 0, 1'b0, '0);
            press(1'b0, 1'b0, 6, 0, 1'b0, '0);
            press(1'b1, 1'b0, n, $urandom_range(6, 9), 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        int stop_at;
        reset_lock_model();
        // levels are active low; expectation pinned on the last held tick where set
        drill_rows = '{
            '{1'b1, 1'b1, 10'd1,   4'd0, 1'b1, '{LED_GREEN,  1'b0, EVT_NONE,   3'd0}},
            '{1'b0, 1'b1, 10'd5,   4'd1, 1'b1, '{LED_GREEN,  1'b0, EVT_NONE,   3'd0}},
            '{1'b0, 1'b1, 10'd6,   4'd6, 1'b1, '{LED_GREEN,  1'b1, EVT_NONE,   3'd1}},
            '{1'b1, 1'b0, 10'd9,   4'd6, 1'b1, '{LED_GREEN,  1'b0, EVT_NONE,   3'd2}},
            '{1'b0, 1'b0, 10'd6,   4'd6, 1'b1, '{LED_GREEN,  1'b1, EVT_NONE,   3'd4}},
            '{1'b0, 1'b1, 10'd6,   4'd6, 1'b1, '{LED_GREEN,  1'b1, EVT_NONE,   3'd5}},
            '{1'b0, 1'b0, 10'd6,   4'd6, 1'b1, '{LED_RED,    1'b1, EVT_STORED, 3'd0}},
            '{1'b1, 1'b0, 10'd6,   4'd6, 1'b1, '{LED_RED,    1'b1, EVT_NONE,   3'd1}},
            '{1'b1, 1'b0, 10'd6,   4'd6, 1'b0, '0},
            '{1'b1, 1'b0, 10'd6,   4'd6, 1'b0, '0},
            '{1'b1, 1'b0, 10'd6,   4'd6, 1'b0, '0},
            '{1'b1, 1'b0, 10'd6,   4'd6, 1'b0, '0},
            '{1'b0, 1'b1, 10'd6,   4'd6, 1'b1, '{LED_YELLOW, 1'b1, EVT_WRONG,  3'd6}},
            '{1'b0, 1'b1, 10'd700, 4'd6, 1'b1, '{LED_RED,    1'b0, EVT_NONE,   3'd0}},
            '{1'b0, 1'b1, 10'd6,   4'd6, 1'b0, '0},
            '{1'b1, 1'b0, 10'd6,   4'd6, 1'b0, '0},
            '{1'b0, 1'b0, 10'd6,   4'd6, 1'b0, '0},
            '{1'b0, 1'b1, 10'd6,   4'd6, 1'b0, '0},
            '{1'b0, 1'b1, 10'd6,   4'd6, 1'b1, '{LED_GREEN,  1'b1, EVT_OPEN,   3'd0}},
            '{1'b1, 1'b1, 10'd3,   4'd0, 1'b0, '0}
        };
        phases[0] = '{10'd3,    10'd2,    12'd100, 7'd15};
        phases[1] = '{10'd0,    10'h3E0,  12'd100, 7'd0};
        phases[2] = '{10'd1,    10'd31,   12'd100, 7'd40};
        phases[3] = '{10'd1023, 10'd1,    12'd200, 7'd15};
        for (int p = 4; p < NUM_PHASES; p++) begin
            phases[p].period       = CFG_DATA_W'($urandom_range(1, 6));
            phases[p].toggles_word = CFG_DATA_W'($urandom_range(1, 5));
            phases[p].ticks        = 12'd50;
            phases[p].gap_pct      = 7'($urandom_range(0, 2) * 20);
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        gap_pct = 15;
        foreach (drill_rows[i])
            press(drill_rows[i].a_level, drill_rows[i].b_level, drill_rows[i].hold,
                  drill_rows[i].rel, drill_rows[i].fixed_en, drill_rows[i].fixed);

        foreach (phases[p]) begin
            drain_results();
            write_flash_cfg(phases[p].period, phases[p].toggles_word);
            gap_pct = phases[p].gap_pct;
            stop_at = ticks_sent + phases[p].ticks;
            while (ticks_sent < stop_at)
                random_burst();
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("two_key_code_lock_tb passed");
        else
            $display("two_key_code_lock_tb failed");
        $finish;
    end

endmodule
